// ===== sv/tcdo_pkg.sv =====
// Shared constants and controller/datapath interface types for the triangle counter.
package tcdo_pkg;

  localparam int unsigned MaxVerticesDef = 1024;
  localparam int unsigned MaxEdgesDef    = 16384;

  localparam int unsigned VertexW = 10;
  localparam int unsigned VcountW = 11;
  localparam int unsigned CountW  = 32;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpCount = 1'b1;

  // controller -> datapath actions
  typedef struct packed {
    logic clr_step;
    logic ld_start;
    logic ld_ovf;
    logic ld_finish;
    logic b_init;
    logic b_take_deg;
    logic b_issue_adeg;
    logic b_decide;
    logic b_row;
    logic c_init;
    logic c_take_src;
    logic c_take_a0;
    logic c_take_a1;
    logic c_take_b0;
    logic c_take_b1;
    logic c_issue_x;
    logic c_take_x;
    logic c_probe;
    logic c_resolve;
    logic c_next_edge;
    logic c_next_j;
  } cmd_t;

  // datapath -> controller flags
  typedef struct packed {
    logic clr_last;
    logic ld_full;
    logic row_live;
    logic j_last;
    logic i_last;
    logic e_done;
    logic j_done;
    logic srch_done;
    logic hit;
  } sts_t;

endpackage

// ===== sv/tcdo_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tcdo_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tcdo_ctrl.sv =====
// Sequencing state machine for load, kept-list build and intersection count.
module tcdo_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          op_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  tcdo_pkg::sts_t sts_i,
  output tcdo_pkg::cmd_t cmd_o
);

  localparam logic [4:0] SClr  = 5'd0;
  localparam logic [4:0] SIdle = 5'd1;
  localparam logic [4:0] SLd1  = 5'd2;
  localparam logic [4:0] SB0   = 5'd3;
  localparam logic [4:0] SB1   = 5'd4;
  localparam logic [4:0] SBj0  = 5'd5;
  localparam logic [4:0] SBj1  = 5'd6;
  localparam logic [4:0] SBj2  = 5'd7;
  localparam logic [4:0] SBrow = 5'd8;
  localparam logic [4:0] SC0   = 5'd9;
  localparam logic [4:0] SC1   = 5'd10;
  localparam logic [4:0] SC2   = 5'd11;
  localparam logic [4:0] SC3   = 5'd12;
  localparam logic [4:0] SC4   = 5'd13;
  localparam logic [4:0] SC5   = 5'd14;
  localparam logic [4:0] SC6   = 5'd15;
  localparam logic [4:0] SC7   = 5'd16;
  localparam logic [4:0] SC8   = 5'd17;
  localparam logic [4:0] SC9   = 5'd18;
  localparam logic [4:0] SOut  = 5'd19;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      SClr: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = SIdle;
      end
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (op_i == tcdo_pkg::OpCount) begin
            cmd_o.b_init = 1'b1;
            state_d = SB0;
          end else if (sts_i.ld_full) begin
            cmd_o.ld_ovf = 1'b1;
          end else begin
            cmd_o.ld_start = 1'b1;
            state_d = SLd1;
          end
        end
      end
      SLd1: begin
        cmd_o.ld_finish = 1'b1;
        state_d = SIdle;
      end
      SB0: begin
        state_d = SB1;
      end
      SB1: begin
        cmd_o.b_take_deg = 1'b1;
        state_d = sts_i.row_live ? SBj0 : SBrow;
      end
      SBj0: begin
        state_d = SBj1;
      end
      SBj1: begin
        cmd_o.b_issue_adeg = 1'b1;
        state_d = SBj2;
      end
      SBj2: begin
        cmd_o.b_decide = 1'b1;
        state_d = sts_i.j_last ? SBrow : SBj0;
      end
      SBrow: begin
        cmd_o.b_row = 1'b1;
        if (sts_i.i_last) begin
          cmd_o.c_init = 1'b1;
          state_d = SC0;
        end else begin
          state_d = SB0;
        end
      end
      SC0: begin
        if (sts_i.e_done) begin
          state_d = SOut;
        end else begin
          state_d = SC1;
        end
      end
      SC1: begin
        cmd_o.c_take_src = 1'b1;
        state_d = SC2;
      end
      SC2: begin
        cmd_o.c_take_a0 = 1'b1;
        state_d = SC3;
      end
      SC3: begin
        cmd_o.c_take_a1 = 1'b1;
        state_d = SC4;
      end
      SC4: begin
        cmd_o.c_take_b0 = 1'b1;
        state_d = SC5;
      end
      SC5: begin
        cmd_o.c_take_b1 = 1'b1;
        state_d = SC6;
      end
      SC6: begin
        if (sts_i.j_done) begin
          cmd_o.c_next_edge = 1'b1;
          state_d = SC0;
        end else begin
          cmd_o.c_issue_x = 1'b1;
          state_d = SC7;
        end
      end
      SC7: begin
        cmd_o.c_take_x = 1'b1;
        state_d = SC8;
      end
      SC8: begin
        if (sts_i.srch_done) begin
          cmd_o.c_next_j = 1'b1;
          state_d = SC6;
        end else begin
          cmd_o.c_probe = 1'b1;
          state_d = SC9;
        end
      end
      SC9: begin
        cmd_o.c_resolve = 1'b1;
        state_d = sts_i.hit ? SC6 : SC8;
      end
      SOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClr;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/tcdo_dp.sv =====
// Datapath: degree, edge and kept-list memories, counters and search registers.
module tcdo_dp #(
  parameter int unsigned MaxVertices = tcdo_pkg::MaxVerticesDef,
  parameter int unsigned MaxEdges    = tcdo_pkg::MaxEdgesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tcdo_pkg::VcountW-1:0]  cfg_wdata_i,
  input  logic [tcdo_pkg::VertexW-1:0]  source_vertex_i,
  input  logic [tcdo_pkg::VertexW-1:0]  dest_vertex_i,
  input  tcdo_pkg::cmd_t                cmd_i,
  output tcdo_pkg::sts_t                sts_o,
  output logic [tcdo_pkg::CountW-1:0]   triangle_count_o,
  output logic                          edge_overflow_o
);

  localparam int unsigned VW = $clog2(MaxVertices);
  localparam int unsigned EW = $clog2(MaxEdges);
  localparam int unsigned CW = $clog2(MaxEdges + 1);
  localparam int unsigned IW = $clog2(MaxVertices + 1);

  // vertex ids reduce modulo the (power of two) vertex capacity
  function automatic logic [VW-1:0] vmod(input logic [tcdo_pkg::VertexW-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return t[VW-1:0];
  endfunction

  function automatic logic [EW-1:0] ewrap(input logic [CW:0] s);
    logic [CW:0] t;
    t = s;
    if (32'(s) >= MaxEdges) t = s - (CW+1)'(MaxEdges);
    return t[EW-1:0];
  endfunction

  logic [VW-1:0] clr_q, s_q, a_q, srca_q, dstb_q, x_q;
  logic [CW-1:0] edges_q, base_q, end_q, j_q, dh_q, k_q, e_q;
  logic [CW-1:0] pa0_q, pb0_q, m_q, n_q, abase_q, bbase_q, jj_q, r_q;
  logic signed [CW:0] bot_q, top_q;
  logic [IW-1:0] i_q;
  logic [tcdo_pkg::VcountW-1:0] vc_q;
  logic [tcdo_pkg::CountW-1:0] total_q;
  logic ovf_q;

  // memory ports
  logic          deg_we;
  logic [VW-1:0] deg_wa, deg_ra;
  logic [CW-1:0] deg_wd, deg_rd;
  logic [EW-1:0] ed_ra;
  logic [VW-1:0] ed_rd;
  logic          krs_we;
  logic [IW-1:0] krs_wa, krs_ra;
  logic [CW-1:0] krs_wd, krs_rd;
  logic          kept_we;
  logic [EW-1:0] kd_ra;
  logic [VW-1:0] kd_rd, ks_rd;

  logic          keep;
  logic [CW+1:0] mid_sum;
  logic [CW-1:0] mid;
  logic [CW-1:0] nb;

  assign keep = (dh_q < deg_rd) || ((dh_q == deg_rd) && (32'(i_q) < 32'(a_q)));
  assign mid_sum = (CW+2)'(top_q) + (CW+2)'(bot_q);
  assign mid = mid_sum[CW:1];
  assign nb = krs_rd - pb0_q;

  always_comb begin
    deg_we = cmd_i.clr_step | cmd_i.ld_finish;
    deg_wa = cmd_i.clr_step ? clr_q : s_q;
    deg_wd = cmd_i.clr_step ? '0 : deg_rd + CW'(1);
    if (cmd_i.ld_start)          deg_ra = vmod(source_vertex_i);
    else if (cmd_i.b_issue_adeg) deg_ra = ed_rd;
    else                         deg_ra = i_q[VW-1:0];

    ed_ra = j_q[EW-1:0];

    krs_we = cmd_i.b_init | cmd_i.b_row;
    krs_wa = cmd_i.b_row ? i_q + IW'(1) : '0;
    krs_wd = cmd_i.b_row ? k_q : '0;
    if (cmd_i.c_take_src)     krs_ra = IW'(ks_rd);
    else if (cmd_i.c_take_a0) krs_ra = IW'(srca_q) + IW'(1);
    else if (cmd_i.c_take_a1) krs_ra = IW'(dstb_q);
    else                      krs_ra = IW'(dstb_q) + IW'(1);

    kept_we = cmd_i.b_decide & keep;
    if (cmd_i.c_issue_x)    kd_ra = ewrap((CW+1)'(bbase_q) + (CW+1)'(jj_q));
    else if (cmd_i.c_probe) kd_ra = ewrap((CW+1)'(abase_q) + (CW+1)'(mid));
    else                    kd_ra = e_q[EW-1:0];
  end

  tcdo_ram #(.Width(CW), .Depth(MaxVertices)) u_deg (
    .clk_i, .we_i(deg_we), .waddr_i(deg_wa), .wdata_i(deg_wd),
    .raddr_i(deg_ra), .rdata_o(deg_rd)
  );

  tcdo_ram #(.Width(VW), .Depth(MaxEdges)) u_edest (
    .clk_i, .we_i(cmd_i.ld_start), .waddr_i(edges_q[EW-1:0]),
    .wdata_i(vmod(dest_vertex_i)), .raddr_i(ed_ra), .rdata_o(ed_rd)
  );

  tcdo_ram #(.Width(CW), .Depth(MaxVertices + 1)) u_krs (
    .clk_i, .we_i(krs_we), .waddr_i(krs_wa), .wdata_i(krs_wd),
    .raddr_i(krs_ra), .rdata_o(krs_rd)
  );

  tcdo_ram #(.Width(VW), .Depth(MaxEdges)) u_kdst (
    .clk_i, .we_i(kept_we), .waddr_i(k_q[EW-1:0]), .wdata_i(a_q),
    .raddr_i(kd_ra), .rdata_o(kd_rd)
  );

  tcdo_ram #(.Width(VW), .Depth(MaxEdges)) u_ksrc (
    .clk_i, .we_i(kept_we), .waddr_i(k_q[EW-1:0]), .wdata_i(i_q[VW-1:0]),
    .raddr_i(e_q[EW-1:0]), .rdata_o(ks_rd)
  );

  always_comb begin
    sts_o.clr_last  = (32'(clr_q) == MaxVertices - 1);
    sts_o.ld_full   = (32'(edges_q) == MaxEdges);
    sts_o.row_live  = (32'(i_q) < 32'(vc_q)) && (deg_rd != '0);
    sts_o.j_last    = (j_q + CW'(1) == end_q);
    sts_o.i_last    = (32'(i_q) == MaxVertices - 1);
    sts_o.e_done    = (e_q == k_q);
    sts_o.j_done    = (jj_q == n_q);
    sts_o.srch_done = (top_q < bot_q);
    sts_o.hit       = (x_q == kd_rd);
  end

  // control-side counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      edges_q <= '0;
      ovf_q   <= 1'b0;
      vc_q    <= '0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + VW'(1);
      if (cmd_i.ld_start) edges_q <= edges_q + CW'(1);
      if (cmd_i.ld_ovf) ovf_q <= 1'b1;
      if (cfg_we_i) vc_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_start) s_q <= vmod(source_vertex_i);
    // kept-list build
    if (cmd_i.b_init) begin
      i_q    <= '0;
      base_q <= '0;
      k_q    <= '0;
    end
    if (cmd_i.b_take_deg) begin
      dh_q  <= deg_rd;
      j_q   <= base_q;
      end_q <= base_q + deg_rd;
    end
    if (cmd_i.b_issue_adeg) a_q <= ed_rd;
    if (cmd_i.b_decide) begin
      j_q <= j_q + CW'(1);
      if (keep) k_q <= k_q + CW'(1);
    end
    if (cmd_i.b_row) begin
      base_q <= end_q;
      i_q    <= i_q + IW'(1);
    end
    // intersection count
    if (cmd_i.c_init) begin
      e_q     <= '0;
      total_q <= '0;
    end
    if (cmd_i.c_take_src) begin
      srca_q <= ks_rd;
      dstb_q <= kd_rd;
    end
    if (cmd_i.c_take_a0) pa0_q <= krs_rd;
    if (cmd_i.c_take_a1) m_q <= krs_rd - pa0_q;
    if (cmd_i.c_take_b0) pb0_q <= krs_rd;
    if (cmd_i.c_take_b1) begin
      jj_q <= '0;
      if (m_q < nb) begin
        m_q     <= nb;
        n_q     <= m_q;
        abase_q <= pb0_q;
        bbase_q <= pa0_q;
      end else begin
        n_q     <= nb;
        abase_q <= pa0_q;
        bbase_q <= pb0_q;
      end
    end
    if (cmd_i.c_next_edge) e_q <= e_q + CW'(1);
    if (cmd_i.c_take_x) begin
      x_q   <= kd_rd;
      bot_q <= '0;
      top_q <= $signed({1'b0, m_q}) - (CW+1)'(1);
    end
    if (cmd_i.c_probe) r_q <= mid;
    if (cmd_i.c_next_j) jj_q <= jj_q + CW'(1);
    if (cmd_i.c_resolve) begin
      if (x_q == kd_rd) begin
        jj_q <= jj_q + CW'(1);
        if (total_q != '1) total_q <= total_q + tcdo_pkg::CountW'(1);
      end else if (x_q < kd_rd) begin
        top_q <= $signed({1'b0, r_q}) - (CW+1)'(1);
      end else begin
        bot_q <= $signed({1'b0, r_q}) + (CW+1)'(1);
      end
    end
  end

  assign triangle_count_o = total_q;
  assign edge_overflow_o  = ovf_q;

endmodule

// ===== sv/triangle_count_degree_ordered_core.sv =====
// Load: each edge request is an append, then a degree update; ready drops for 1 cycle.
// Count: a pass over every vertex row, and over each edge of a counted row, builds the kept
// lists; then each kept edge fetches the bounds of both lists, and each element of the shorter
// list is binary-searched in the longer one; all steps share the single read port of each
// memory. One request at a time.
// Reset: a clearing pass runs over every entry of the degree memory, in_ready_o low.
// Overflow flag and edge count clear only on reset.
module triangle_count_degree_ordered_core #(
  parameter int unsigned MaxVertices = tcdo_pkg::MaxVerticesDef,
  parameter int unsigned MaxEdges    = tcdo_pkg::MaxEdgesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tcdo_pkg::VcountW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [tcdo_pkg::VertexW-1:0]  source_vertex_i,
  input  logic [tcdo_pkg::VertexW-1:0]  dest_vertex_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tcdo_pkg::CountW-1:0]   triangle_count_o,
  output logic                          edge_overflow_o
);

  tcdo_pkg::cmd_t cmd;
  tcdo_pkg::sts_t sts;

  tcdo_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i,
    .out_valid_o, .out_ready_i, .sts_i(sts), .cmd_o(cmd)
  );

  tcdo_dp #(.MaxVertices(MaxVertices), .MaxEdges(MaxEdges)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .source_vertex_i, .dest_vertex_i,
    .cmd_i(cmd), .sts_o(sts), .triangle_count_o, .edge_overflow_o
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(edge_overflow_o))
    else $error("overflow flag cleared without reset");

  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(triangle_count_o))
    else $error("triangle count changed while held");
`endif

endmodule
